FILE: rtl/rcpts_pkg.sv
// Package for the RC pulse toggle switch: field widths, codes, register
// indexes and reset values of the configuration registers.
// No dependencies.
package rcpts_pkg;

	localparam int CFG_W        = 16;
	localparam int WIDTH_W      = 16;
	localparam int IN_TDATA_W   = 16;
	localparam int OUT_TDATA_W  = 8;
	localparam int REG_IDX_W    = 2;
	localparam int COUNT_WIDTH  = 16;

	// input kinds carried on tuser
	localparam logic OP_WIDTH = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_OFF_MAX   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ON_MIN    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_PHASE     = 2'd3;

	localparam logic [CFG_W-1:0] OFF_MAX_RESET = 16'd350;
	localparam logic [CFG_W-1:0] ON_MIN_RESET  = 16'd400;
	localparam logic [CFG_W-1:0] WINDOW_RESET  = 16'd500;
	localparam logic [CFG_W-1:0] PHASE_RESET   = 16'd80;

	// pulse train lengths in phases
	localparam logic [1:0] PHASES_DOUBLE = 2'd1;
	localparam logic [1:0] PHASES_SINGLE = 2'd3;

	typedef enum logic [1:0] {
		LV_UNKNOWN = 2'd0,
		LV_ON      = 2'd1,
		LV_OFF     = 2'd2
	} lvl_t;

endpackage

FILE: rtl/rc_pulse_toggle_switch_core.sv
// Top level of the RC pulse toggle switch: input register, single-pass
// state update and output register.
// Depends on rcpts_pkg.

// Each transfer on the slave side is either a measured receiver pulse width
// (tuser 0) or one time tick (tuser 1) and yields exactly one result on the
// master side, showing line level, switch state, window and pulse train
// status after that item. The block takes one item per clock cycle while
// the master side is not stalled; each item passes the input register,
// then the output register, and the state update between the two
// registers is a handful of compares and counter steps on COUNT_WIDTH
// bit counters.
// The user must write thresholds and tick counts through the plain write
// port only while no item is in flight; the block does not enforce this.
module rc_pulse_toggle_switch_core #(
	parameter int COUNT_WIDTH = rcpts_pkg::COUNT_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rcpts_pkg::IN_TDATA_W-1:0]    s_tdata,  // [15:0] width
	input  logic                                s_tuser,  // [0] op
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] switch_state, [2:1] line_level, [3] window_open, [4] pulse_busy, [7:5] zero
	output logic [rcpts_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                                wr_en,
	input  logic [rcpts_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [rcpts_pkg::CFG_W-1:0]         wr_data
);
	import rcpts_pkg::*;

	localparam int CW = COUNT_WIDTH;

	// configuration
	logic [CFG_W-1:0] off_max_q, on_min_q, window_q, phase_q;

	// input stage
	logic               valid_s1;
	logic               op_s1;
	logic [WIDTH_W-1:0] width_s1;
	logic               advance;

	// block state
	lvl_t          lvl_q, lvl_d;
	logic          win_act_q, win_act_d;
	logic [CW-1:0] win_left_q, win_left_d;
	logic          second_q, second_d;
	logic          out_q, out_d;
	logic [1:0]    phases_q, phases_d;
	logic [CW-1:0] pcount_q, pcount_d;

	logic          toggled;
	logic [CW-1:0] pc_inc;
	logic [CW-1:0] win_sat, phase_sat;

	// output stage
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// saturate the tick counts to the counter range; zero acts as one
	generate
		if (CW >= CFG_W) begin : g_wide
			assign win_sat   = (window_q == '0) ? CW'(1) : CW'(window_q);
			assign phase_sat = (phase_q == '0) ? CW'(1) : CW'(phase_q);
		end else begin : g_narrow
			assign win_sat   = (window_q == '0) ? CW'(1) :
				(|window_q[CFG_W-1:CW]) ? {CW{1'b1}} : window_q[CW-1:0];
			assign phase_sat = (phase_q == '0) ? CW'(1) :
				(|phase_q[CFG_W-1:CW]) ? {CW{1'b1}} : phase_q[CW-1:0];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_max_q <= OFF_MAX_RESET;
			on_min_q  <= ON_MIN_RESET;
			window_q  <= WINDOW_RESET;
			phase_q   <= PHASE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OFF_MAX: off_max_q <= wr_data;
				REG_ON_MIN:  on_min_q  <= wr_data;
				REG_WINDOW:  window_q  <= wr_data;
				REG_PHASE:   phase_q   <= wr_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			width_s1 <= s_tdata[WIDTH_W-1:0];
		end
	end

	always_comb begin
		lvl_d      = lvl_q;
		win_act_d  = win_act_q;
		win_left_d = win_left_q;
		second_d   = second_q;
		out_d      = out_q;
		phases_d   = phases_q;
		pcount_d   = pcount_q;
		toggled    = 1'b0;
		pc_inc     = pcount_q + CW'(1);
		if (op_s1 == OP_WIDTH) begin
			// OFF test first: it wins when the thresholds overlap
			if (width_s1 <= off_max_q) begin
				toggled = (lvl_q == LV_ON);
				lvl_d   = LV_OFF;
			end else if (width_s1 >= on_min_q) begin
				toggled = (lvl_q == LV_OFF);
				lvl_d   = LV_ON;
			end
			if (toggled) begin
				if (!win_act_q) begin
					win_act_d  = 1'b1;
					win_left_d = win_sat;
					second_d   = 1'b0;
				end else begin
					second_d = 1'b1;
				end
			end
		end else begin
			// advance the running train, then let an expiring window restart it
			if (phases_q != 2'd0) begin
				if (pc_inc >= phase_sat) begin
					pcount_d = '0;
					out_d    = ~out_q;
					phases_d = phases_q - 2'd1;
				end else begin
					pcount_d = pc_inc;
				end
			end
			if (win_act_q) begin
				if (win_left_q <= CW'(1)) begin
					win_act_d  = 1'b0;
					win_left_d = '0;
					phases_d   = second_q ? PHASES_DOUBLE : PHASES_SINGLE;
					second_d   = 1'b0;
					out_d      = 1'b1;
					pcount_d   = '0;
				end else begin
					win_left_d = win_left_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q      <= LV_UNKNOWN;
			win_act_q  <= 1'b0;
			win_left_q <= '0;
			second_q   <= 1'b0;
			out_q      <= 1'b0;
			phases_q   <= 2'd0;
			pcount_q   <= '0;
		end else if (advance) begin
			lvl_q      <= lvl_d;
			win_act_q  <= win_act_d;
			win_left_q <= win_left_d;
			second_q   <= second_d;
			out_q      <= out_d;
			phases_q   <= phases_d;
			pcount_q   <= pcount_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {3'b000, (phases_d != 2'd0), win_act_d, lvl_d, out_d};
		end
	end

	// window counter is non-zero exactly while the window runs
	a_win_left: assert property (@(posedge clk) disable iff (!arst_n)
		win_act_q == (win_left_q != '0))
		else $error("window counter out of step with window flag");

	a_second_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> win_act_q)
		else $error("second toggle marked outside a window");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phases_q == 2'd0) |-> (pcount_q == '0))
		else $error("phase counter running with no pulse train");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(width_s1) && $stable(op_s1)))
		else $error("stalled input item lost");

	a_result_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_valid_q)
		else $error("advanced item produced no result");

endmodule
